// ----- sv/ksm_pkg.sv -----
// Shared types and constants of the key sequence matcher.
// Used by ksm_cell and key_sequence_matcher_core; depends on nothing else.
package ksm_pkg;

    localparam int unsigned KEY_W    = 29;  // key code plus modifiers
    localparam int unsigned CODE_W   = 25;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned SLOT_W   = 5;
    localparam int unsigned POS_W    = 2;
    localparam int unsigned SLEN_W   = 3;
    localparam int unsigned IDXCMP_W = 9;   // wide enough for any cell index
    localparam int unsigned CMP_W    = 5;   // wide enough for lengths and steps

    typedef enum logic [1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_WRITE   = 2'd2
    } t_cmd;

    localparam logic KIND_ACT   = 1'b0;
    localparam logic KIND_DEACT = 1'b1;

    // saturating count of completed bindings
    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_ONE  = 2'd1;
    localparam logic [1:0] HITS_MANY = 2'd2;

    typedef logic [KEY_W-1:0] t_key_word;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CODE_W-1:0] key_code;
        logic [3:0]        modifiers;
        logic              auto_repeat;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [SLEN_W-1:0] seq_length;
        logic [ID_W-1:0]   binding_id;
    } t_item;

    typedef struct packed {
        logic            event_kind;
        logic [ID_W-1:0] binding;
        logic            last_item;
    } t_result;

    // scan token handed from cell to cell
    typedef struct packed {
        logic            valid;
        logic [1:0]      hits;
        logic [ID_W-1:0] hit_id;
        logic            open;
    } t_token;

    // table write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [SLEN_W-1:0] len;
        t_key_word         word;
        logic [ID_W-1:0]   id;
    } t_tbl_wr;

endpackage

// ----- sv/ksm_cell.sv -----
// One binding slot of the matcher chain: key words, length, id, candidate bit.
// Depends on ksm_pkg. Evaluates the scan token and hands it to the next cell.
module ksm_cell import ksm_pkg::*; #(
    parameter int unsigned IDX     = 0,
    parameter int unsigned MAX_LEN = 4,
    localparam int unsigned LW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_tbl_wr         i_wr,
    input  t_key_word       i_key,
    input  logic [LW-1:0]   i_step,
    input  t_token          i_tok,
    output t_token          o_tok
);

    localparam int unsigned LENW = $clog2(MAX_LEN + 1);
    localparam logic [IDXCMP_W-1:0] IDX_C = IDXCMP_W'(IDX);
    localparam logic [CMP_W-1:0] MAXLEN_C = CMP_W'(MAX_LEN);

    t_key_word         r_keys [MAX_LEN];
    logic [LENW-1:0]   r_len;
    logic [ID_W-1:0]   r_id;
    logic              r_cand;
    t_token            r_tok;

    logic              n_cand;
    t_token            n_tok;
    logic              wr_hit;
    logic              was;
    logic              key_eq;
    logic [CMP_W-1:0]  len_c;
    logic [CMP_W-1:0]  step_c;
    logic [LENW-1:0]   wr_len;

    assign len_c  = CMP_W'(r_len);
    assign step_c = CMP_W'(i_step);
    assign key_eq = (r_keys[i_step] == i_key);
    assign was    = (i_step == '0) ? (r_len != '0) : r_cand;

    assign wr_hit = i_wr.en
                 && ({{(IDXCMP_W-SLOT_W){1'b0}}, i_wr.slot} == IDX_C)
                 && ({{(CMP_W-POS_W){1'b0}}, i_wr.pos} < MAXLEN_C);
    assign wr_len = ({{(CMP_W-SLEN_W){1'b0}}, i_wr.len} > MAXLEN_C)
                  ? LENW'(MAX_LEN) : LENW'(i_wr.len);

    always_comb begin
        n_cand = r_cand;
        n_tok  = i_tok;
        if (i_tok.valid) begin
            n_cand = 1'b0;
            if (was && (len_c > step_c) && key_eq) begin
                if (len_c == step_c + CMP_W'(1)) begin
                    n_tok.hits   = (i_tok.hits == HITS_NONE) ? HITS_ONE : HITS_MANY;
                    n_tok.hit_id = r_id;
                end else begin
                    n_cand     = 1'b1;
                    n_tok.open = 1'b1;
                end
            end
        end
        if (wr_hit) begin
            n_cand = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_cand <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_cand <= n_cand;
            r_tok  <= n_tok;
            if (wr_hit) begin
                r_keys[LW'(i_wr.pos)] <= i_wr.word;
                r_len                 <= wr_len;
                r_id                  <= i_wr.id;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- sv/key_sequence_matcher_core.sv -----
// Channel   Direction  Handshake                      Payload
// command   in         start high, busy low           i_item   (t_item)
// result    out        o_strobe, one cycle, no stall  o_result (t_result)
//
// A key press launches a token that walks the cell chain one binding per cycle, and its
// results, up to two, leave one per cycle after it.
// Busy stays low for a release or table write.
// Reset (synchronous, i_rst_n low) disables every binding and clears candidates,
// the match step and the active binding. Results cannot be held off.
// Top level of the key sequence matcher; depends on ksm_pkg and ksm_cell.
module key_sequence_matcher_core import ksm_pkg::*; #(
    parameter int unsigned NUM_BINDINGS = 32,
    parameter int unsigned MAX_LEN      = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int unsigned LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT2} t_state;

    t_state          r_state, n_state;
    logic            r_launch, n_launch;
    logic [LW-1:0]   r_step, n_step;
    t_key_word       r_key, n_key;
    logic [ID_W-1:0] r_active, n_active;
    logic [ID_W-1:0] r_deact_id, n_deact_id;
    logic [ID_W-1:0] r_act_id, n_act_id;
    logic            r_strobe, n_strobe;
    t_result         r_result, n_result;

    logic    accept;
    logic    is_press;
    logic    is_rel;
    logic    act;
    t_tbl_wr wr;
    t_token  tok [NUM_BINDINGS+1];

    assign accept   = start && (r_state == S_IDLE);
    assign is_press = accept && (i_item.cmd == CMD_PRESS) && !i_item.auto_repeat;
    assign is_rel   = accept && (i_item.cmd == CMD_RELEASE) && !i_item.auto_repeat;

    always_comb begin
        wr.en   = accept && (i_item.cmd == CMD_WRITE);
        wr.slot = i_item.slot;
        wr.pos  = i_item.position;
        wr.len  = i_item.seq_length;
        wr.word = {i_item.modifiers, i_item.key_code};
        wr.id   = i_item.binding_id;
    end

    always_comb begin
        tok[0]        = '0;
        tok[0].valid  = r_launch;
    end

    for (genvar g = 0; g < NUM_BINDINGS; g++) begin : g_cell
        ksm_cell #(
            .IDX     (g),
            .MAX_LEN (MAX_LEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_key   (r_key),
            .i_step  (r_step),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign act = !tok[NUM_BINDINGS].open && (tok[NUM_BINDINGS].hits == HITS_ONE);

    always_comb begin
        n_state    = r_state;
        n_launch   = 1'b0;
        n_step     = r_step;
        n_key      = r_key;
        n_active   = r_active;
        n_deact_id = r_deact_id;
        n_act_id   = r_act_id;
        n_strobe   = 1'b0;
        n_result   = r_result;
        case (r_state)
            S_IDLE: begin
                if (is_rel && (r_active != '0)) begin
                    n_strobe = 1'b1;
                    n_result = '{event_kind: KIND_DEACT, binding: r_active, last_item: 1'b1};
                    n_active = '0;
                end
                if (is_press) begin
                    // hold the deactivation until we know whether an activation follows
                    n_deact_id = r_active;
                    n_active   = '0;
                    n_key      = {i_item.modifiers, i_item.key_code};
                    n_launch   = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tok[NUM_BINDINGS].valid) begin
                    n_step  = tok[NUM_BINDINGS].open ? LW'(r_step + 1'b1) : '0;
                    n_state = S_IDLE;
                    if (act) begin
                        n_active = tok[NUM_BINDINGS].hit_id;
                        n_act_id = tok[NUM_BINDINGS].hit_id;
                    end
                    if (r_deact_id != '0) begin
                        n_strobe   = 1'b1;
                        n_result   = '{event_kind: KIND_DEACT, binding: r_deact_id,
                                       last_item: !act};
                        n_deact_id = '0;
                        if (act) begin
                            n_state = S_EMIT2;
                        end
                    end else if (act) begin
                        n_strobe = 1'b1;
                        n_result = '{event_kind: KIND_ACT, binding: tok[NUM_BINDINGS].hit_id,
                                     last_item: 1'b1};
                    end
                end
            end
            S_EMIT2: begin
                n_strobe = 1'b1;
                n_result = '{event_kind: KIND_ACT, binding: r_act_id, last_item: 1'b1};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launch   <= 1'b0;
            r_step     <= '0;
            r_active   <= '0;
            r_deact_id <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launch   <= n_launch;
            r_step     <= n_step;
            r_active   <= n_active;
            r_deact_id <= n_deact_id;
            r_strobe   <= n_strobe;
        end
        r_key    <= n_key;
        r_act_id <= n_act_id;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // the token may only reach the chain end while a scan is running
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[NUM_BINDINGS].valid |-> (r_state == S_SCAN))
        else $error("scan token at chain end outside a scan");

    // the second result of a press is always a final activation
    a_emit2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2) |=> (o_strobe && o_result.last_item
                                  && (o_result.event_kind == KIND_ACT)))
        else $error("second result is not a final activation");

    // a deactivation never names the empty binding
    a_deact_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.event_kind == KIND_DEACT)) |-> (o_result.binding != '0))
        else $error("deactivation of binding zero");

    // a table write leaves the block free in the next cycle
    a_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.cmd == CMD_WRITE)) |=> (!busy && !o_strobe))
        else $error("table write made the block busy or gave a result");

    // the match step stays inside the sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_step) < CMP_W'(MAX_LEN))
        else $error("match step out of range");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for key_sequence_matcher_core: drives presses, releases and
// binding table writes, predicts the activation and deactivation words, and checks them.
// Depends on ksm_pkg and the key_sequence_matcher_core RTL.
import ksm_pkg::*;

class shortcut_board;
    localparam int NB = 32;
    localparam int ML = 4;

    bit [KEY_W-1:0]  keys [NB][ML];
    bit [SLEN_W-1:0] lens [NB];
    bit [ID_W-1:0]   idents [NB];
    bit [NB-1:0]     cand;
    int unsigned     step;
    bit [ID_W-1:0]   active;

    t_result due_events [$];
    int mismatches;
    int checked;
    int n_press;
    int n_lift;
    int n_write;
    int n_ignored;
    int n_act;
    int n_deact;
    int deepest;

    // predict the words caused by one accepted command word
    function void take_word(t_item w);
        t_key_word   kw;
        int unsigned hits;
        int unsigned hit_slot;
        bit          open_seq;
        bit          was;
        int          n0;
        t_result     ev;

        kw = {w.modifiers, w.key_code};
        hits = 0;
        hit_slot = 0;
        open_seq = 1'b0;
        if (w.cmd == CMD_WRITE) begin
            n_write++;
            keys[w.slot][w.position] = kw;
            lens[w.slot] = (w.seq_length > 3'd4) ? 3'd4 : w.seq_length;
            idents[w.slot] = w.binding_id;
            cand[w.slot] = 1'b0;
            return;
        end
        if ((w.cmd != CMD_PRESS && w.cmd != CMD_RELEASE) || w.auto_repeat) begin
            n_ignored++;
            return;
        end
        n0 = due_events.size();
        if (active != '0) begin
            ev.event_kind = KIND_DEACT;
            ev.binding = active;
            ev.last_item = 1'b0;
            due_events.push_back(ev);
            active = '0;
            n_deact++;
        end
        if (w.cmd == CMD_PRESS) begin
            n_press++;
            for (int i = 0; i < NB; i++) begin
                was = (step == 0) ? (lens[i] >= 1) : cand[i];
                cand[i] = 1'b0;
                if (!was || lens[i] <= step) continue;
                if (keys[i][step] != kw) continue;
                if (lens[i] == step + 1) begin
                    hits++;
                    hit_slot = i;
                end else begin
                    cand[i] = 1'b1;
                    open_seq = 1'b1;
                end
            end
            if (open_seq) begin
                step++;
                if (step > deepest) deepest = step;
            end else begin
                step = 0;
                if (hits == 1) begin
                    ev.event_kind = KIND_ACT;
                    ev.binding = idents[hit_slot];
                    ev.last_item = 1'b0;
                    due_events.push_back(ev);
                    active = idents[hit_slot];
                    n_act++;
                end
            end
        end else begin
            n_lift++;
        end
        if (due_events.size() > n0) due_events[$].last_item = 1'b1;
    endfunction

    function void check_event(t_result got);
        t_result want;

        checked++;
        if (due_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: kind %0d id %h last %0d",
                         got.event_kind, got.binding, got.last_item);
            return;
        end
        want = due_events.pop_front();
        if (got.event_kind !== want.event_kind || got.binding !== want.binding ||
            got.last_item !== want.last_item) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: expected kind %0d id %h last %0d, got kind %0d id %h last %0d",
                         checked, want.event_kind, want.binding, want.last_item,
                         got.event_kind, got.binding, got.last_item);
        end
    endfunction
endclass

module tb;
    localparam int NB     = 32;
    localparam int ML     = 4;
    localparam int ITEMS  = 1450;
    localparam int CALM   = 120;   // final words sent with no gaps
    localparam int LIMIT  = 2000;
    localparam int SETTLE = NB + 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_strobe;
    t_result o_result;

    shortcut_board sb;

    // generator's copy of the table, used to press stored bindings and to keep lengths off unwritten words
    t_key_word      g_keys [NB][ML];
    bit [SLEN_W-1:0] g_len [NB];
    bit [ML-1:0]    g_mask [NB];
    t_key_word      pool [8];
    int             words_sent;
    bit             idle_mode;
    int             quiet;

    key_sequence_matcher_core #(
        .NUM_BINDINGS(NB),
        .MAX_LEN     (ML)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.take_word(i_item);
            if (o_strobe) sb.check_event(o_result);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", LIMIT);
                $display("key_sequence_matcher_core regression: fail");
                $finish;
            end
        end
    end

    function automatic t_item noise_word();
        bit [63:0] r;

        r = {$urandom, $urandom};
        return t_item'(r[$bits(t_item)-1:0]);
    endfunction

    function automatic t_key_word random_key();
        bit [31:0] r;

        r = $urandom;
        return r[KEY_W-1:0];
    endfunction

    // hold start until the word is taken; insert random gaps outside the final stretch
    task automatic send_word(input t_item it);
        if (words_sent < ITEMS - CALM) begin
            if ($urandom_range(0, 99) < 3) idle_mode = !idle_mode;
            if (idle_mode && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic press_key(input t_key_word kw, input bit rep);
        t_item it;

        it = noise_word();
        it.cmd = CMD_PRESS;
        it.key_code = kw[CODE_W-1:0];
        it.modifiers = kw[KEY_W-1:CODE_W];
        it.auto_repeat = rep;
        send_word(it);
    endtask

    task automatic lift_key(input bit rep);
        t_item it;

        it = noise_word();
        it.cmd = CMD_RELEASE;
        it.auto_repeat = rep;
        send_word(it);
    endtask

    task automatic send_unused();
        t_item it;

        it = noise_word();
        it.cmd = CMD_UNUSED;
        send_word(it);
    endtask

    task automatic write_entry(input int s, input int p, input t_key_word kw,
                               input int len, input bit [ID_W-1:0] id, input bit rep);
        t_item it;

        it = noise_word();
        it.cmd = CMD_WRITE;
        it.slot = SLOT_W'(s);
        it.position = POS_W'(p);
        it.key_code = kw[CODE_W-1:0];
        it.modifiers = kw[KEY_W-1:CODE_W];
        it.seq_length = SLEN_W'(len);
        it.binding_id = id;
        it.auto_repeat = rep;
        g_keys[s][p] = kw;
        g_len[s] = SLEN_W'((len > ML) ? ML : len);
        g_mask[s][p] = 1'b1;
        send_word(it);
    endtask

    function automatic t_key_word pick_key();
        return ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 7)] : random_key();
    endfunction

    function automatic bit [ID_W-1:0] pick_id();
        return ($urandom_range(0, 15) == 0) ? '0 : ID_W'($urandom);
    endfunction

    // write a whole binding back to back so no press sees it half written
    task automatic write_binding();
        int s;
        int len;
        int lim;
        bit [ID_W-1:0] id;

        s = $urandom_range(0, NB - 1);
        len = $urandom_range(0, 7);
        lim = (len > ML) ? ML : len;
        id = pick_id();
        if (lim == 0) begin
            write_entry(s, $urandom_range(0, ML - 1), pick_key(), len, id,
                        1'($urandom_range(0, 1)));
        end else begin
            for (int p = 0; p < lim; p++)
                write_entry(s, p, pick_key(), len, id, $urandom_range(0, 7) == 0);
        end
    endtask

    // change one key word; the length never reaches past the written prefix
    task automatic rewrite_word();
        int s;
        int p;
        int reach;
        bit [ML-1:0] m;

        s = $urandom_range(0, NB - 1);
        p = $urandom_range(0, ML - 1);
        m = g_mask[s];
        m[p] = 1'b1;
        reach = 0;
        while (reach < ML && m[reach]) reach++;
        write_entry(s, p, pick_key(),
                    $urandom_range(0, (reach == ML) ? 7 : reach), pick_id(), 1'b0);
    endtask

    // press a stored binding key by key, now and then broken by other words
    task automatic run_sequence();
        int s;

        s = $urandom_range(0, NB - 1);
        for (int t = 0; t < 8 && g_len[s] == 0; t++) s = $urandom_range(0, NB - 1);
        if (g_len[s] == 0) return;
        for (int p = 0; p < g_len[s]; p++) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: lift_key(1'b0);
                    1: press_key(pool[$urandom_range(0, 7)], 1'b0);
                    default: press_key(g_keys[s][p], 1'b1);
                endcase
            end
            press_key(g_keys[s][p], 1'b0);
        end
    endtask

    initial begin
        int pick;

        sb = new();
        words_sent = 0;
        idle_mode = 1'b1;
        pool[0] = random_key();
        pool[1] = random_key();
        pool[2] = {4'hF, {CODE_W{1'b1}}};
        pool[3] = '0;
        for (int i = 4; i < 8; i++) pool[i] = random_key();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, single-key binding, long binding at the key extremes,
        // id zero, two completions at once, completion with a longer binding still open
        press_key(pool[4], 1'b0);
        lift_key(1'b0);
        write_entry(0, 0, pool[0], 1, 16'h1234, 1'b0);
        press_key(pool[0], 1'b0);
        press_key(pool[0], 1'b0);
        lift_key(1'b0);
        press_key(pool[0], 1'b1);
        send_unused();
        write_entry(31, 0, pool[2], 7, 16'hFFFF, 1'b0);
        write_entry(31, 1, pool[3], 7, 16'hFFFF, 1'b0);
        write_entry(31, 2, pool[0], 4, 16'hFFFF, 1'b1);
        write_entry(31, 3, pool[1], 4, 16'hFFFF, 1'b0);
        press_key(pool[2], 1'b0);
        press_key(pool[3], 1'b0);
        press_key(pool[0], 1'b0);
        press_key(pool[1], 1'b0);
        write_entry(1, 0, pool[1], 1, 16'h0000, 1'b0);
        press_key(pool[1], 1'b0);
        lift_key(1'b0);
        write_entry(2, 0, pool[0], 1, 16'h0001, 1'b0);
        press_key(pool[0], 1'b0);
        write_entry(3, 0, pool[0], 2, 16'h00AA, 1'b0);
        write_entry(3, 1, pool[1], 2, 16'h00AA, 1'b0);
        press_key(pool[0], 1'b0);
        press_key(pool[1], 1'b0);

        while (words_sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) run_sequence();
            else if (pick < 47) write_binding();
            else if (pick < 55) rewrite_word();
            else if (pick < 70) press_key(pool[$urandom_range(0, 7)], 1'b0);
            else if (pick < 77) press_key(random_key(), 1'b0);
            else if (pick < 88) lift_key(1'b0);
            else begin
                case ($urandom_range(0, 2))
                    0: press_key(pick_key(), 1'b1);
                    1: lift_key(1'b1);
                    default: send_unused();
                endcase
            end
        end
        start <= 1'b0;

        while (sb.due_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("run covered %0d presses, %0d releases, %0d table writes, %0d ignored words",
                 sb.n_press, sb.n_lift, sb.n_write, sb.n_ignored);
        $display("%0d activations and %0d deactivations checked, deepest match step %0d",
                 sb.n_act, sb.n_deact, sb.deepest);
        if (sb.mismatches == 0 && sb.due_events.size() == 0) begin
            $display("key_sequence_matcher_core regression: pass");
        end else begin
            $display("%0d mismatches, %0d words never seen", sb.mismatches,
                     sb.due_events.size());
            $display("key_sequence_matcher_core regression: fail");
        end
        $finish;
    end
endmodule
